[rtl/prs_pkg.sv]
// ----------------------------------------------------------------------------
// PRESENT-80 package
// Widths, register indexes, S-boxes and the bit permutation used by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

	localparam int BLOCK_W   = 64;
	localparam int KEY_W     = 80;
	localparam int RK_W      = 64;
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 64;
	localparam int KEY_HI_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

	// Control that travels alongside a block from one cell to the next.
	typedef struct packed {
		logic valid;
		logic decrypt;
	} ctl_t;

	function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
		logic [3:0] y;
		case (x)
			4'h0: y = 4'hC;
			4'h1: y = 4'h5;
			4'h2: y = 4'h6;
			4'h3: y = 4'hB;
			4'h4: y = 4'h9;
			4'h5: y = 4'h0;
			4'h6: y = 4'hA;
			4'h7: y = 4'hD;
			4'h8: y = 4'h3;
			4'h9: y = 4'hE;
			4'hA: y = 4'hF;
			4'hB: y = 4'h8;
			4'hC: y = 4'h4;
			4'hD: y = 4'h7;
			4'hE: y = 4'h1;
			4'hF: y = 4'h2;
			default: y = 4'h0;
		endcase
		return y;
	endfunction

	function automatic logic [3:0] sbox_inv(input logic [3:0] x);
		logic [3:0] y;
		case (x)
			4'h0: y = 4'h5;
			4'h1: y = 4'hE;
			4'h2: y = 4'hF;
			4'h3: y = 4'h8;
			4'h4: y = 4'hC;
			4'h5: y = 4'h1;
			4'h6: y = 4'h2;
			4'h7: y = 4'hD;
			4'h8: y = 4'hB;
			4'h9: y = 4'h4;
			4'hA: y = 4'h6;
			4'hB: y = 4'h3;
			4'hC: y = 4'h0;
			4'hD: y = 4'h7;
			4'hE: y = 4'h9;
			4'hF: y = 4'hA;
			default: y = 4'h0;
		endcase
		return y;
	endfunction

	function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] r;
		r = '0;
		for (int n = 0; n < BLOCK_W / 4; n++) begin
			r[4*n +: 4] = sbox_fwd(s[4*n +: 4]);
		end
		return r;
	endfunction

	function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] r;
		r = '0;
		for (int n = 0; n < BLOCK_W / 4; n++) begin
			r[4*n +: 4] = sbox_inv(s[4*n +: 4]);
		end
		return r;
	endfunction

	// Bit i moves to 16*i mod 63 (bit 63 stays), which is the 6-bit index
	// with its two low bits swapped to the top: {i[1:0], i[5:2]}.
	function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] r;
		r = '0;
		for (int i = 0; i < BLOCK_W; i++) begin
			r[((i & 3) << 4) | (i >> 2)] = s[i];
		end
		return r;
	endfunction

	function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] s);
		logic [BLOCK_W-1:0] r;
		r = '0;
		for (int i = 0; i < BLOCK_W; i++) begin
			r[i] = s[((i & 3) << 4) | (i >> 2)];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/prs_key_cell.sv]
// ----------------------------------------------------------------------------
// PRESENT-80 key schedule cell
// Registers the next 80-bit key register state from its neighbour's state.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_key_cell (
	input  wire logic                         clk,
	input  wire logic [prs_pkg::KEY_W-1:0]    key_prev,
	input  wire logic [prs_pkg::CNT_W-1:0]    rnd_cnt,
	output logic      [prs_pkg::KEY_W-1:0]    key_next
);

	logic [prs_pkg::KEY_W-1:0] rot;
	logic [prs_pkg::KEY_W-1:0] step;
	logic [prs_pkg::KEY_W-1:0] key_q;

	// Rotate left by 61, i.e. right by 19.
	assign rot = {key_prev[18:0], key_prev[prs_pkg::KEY_W-1:19]};

	always_comb begin
		step = rot;
		step[prs_pkg::KEY_W-1 -: 4] = prs_pkg::sbox_fwd(rot[prs_pkg::KEY_W-1 -: 4]);
		step[19:15] = rot[19:15] ^ rnd_cnt;
	end

	always_ff @(posedge clk) begin
		key_q <= step;
	end

	assign key_next = key_q;

endmodule

`default_nettype wire

[rtl/prs_round_cell.sv]
// ----------------------------------------------------------------------------
// PRESENT-80 round cell
// One encryption or decryption round with its own stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_round_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire prs_pkg::ctl_t                 up_ctl,
	input  wire logic [prs_pkg::BLOCK_W-1:0]   up_data,
	output logic                               up_ready,
	input  wire logic [prs_pkg::RK_W-1:0]      enc_rk,
	input  wire logic [prs_pkg::RK_W-1:0]      dec_rk,
	output prs_pkg::ctl_t                      dn_ctl,
	output logic      [prs_pkg::BLOCK_W-1:0]   dn_data,
	input  wire logic                          dn_ready
);

	logic                          valid_q;
	logic                          decrypt_q;
	logic [prs_pkg::BLOCK_W-1:0]   data_q;
	logic [prs_pkg::BLOCK_W-1:0]   enc_res;
	logic [prs_pkg::BLOCK_W-1:0]   dec_res;
	logic                          advance;

	assign enc_res = prs_pkg::perm_fwd(prs_pkg::sub_fwd(up_data ^ enc_rk));
	assign dec_res = prs_pkg::sub_inv(prs_pkg::perm_inv(up_data)) ^ dec_rk;

	// The cell moves on when it is empty or its neighbour takes its block.
	assign advance  = !valid_q || dn_ready;
	assign up_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= up_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && up_ctl.valid) begin
			decrypt_q <= up_ctl.decrypt;
			data_q    <= up_ctl.decrypt ? dec_res : enc_res;
		end
	end

	assign dn_ctl.valid   = valid_q;
	assign dn_ctl.decrypt = decrypt_q;
	assign dn_data        = data_q;

endmodule

`default_nettype wire

[rtl/present80_block_cipher.sv]
// Pipeline: a block accepted at the input passes a chain of ROUNDS round cells, each with
// its register, and then the output register before it appears on block_out.
// Throughput: one block per cycle while no output stall or key change holds the pipeline.
// Reset clears all valid state and the key to zero, then stalls the input while the key
// schedule chain fills; every key write stalls the input in the same way.
// ----------------------------------------------------------------------------
// PRESENT-80 block cipher
// Pipelined PRESENT-80 encryption and decryption with a chain of round cells
// and a parallel chain of key schedule cells.
// ----------------------------------------------------------------------------
`default_nettype none

module present80_block_cipher #(
	parameter int ROUNDS = 31
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [prs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [prs_pkg::CFG_DAT_W-1:0]     cfg_data,
	// input block channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic [prs_pkg::BLOCK_W-1:0]       block_in,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [prs_pkg::BLOCK_W-1:0]       block_out
);

	localparam int BUSY_W = $clog2(ROUNDS + 1);

	// Key registers written through the configuration channel.
	logic [prs_pkg::CFG_DAT_W-1:0]  key_low_q;
	logic [prs_pkg::KEY_HI_W-1:0]   key_high_q;

	// Counts down the cycles that the key chain needs to settle after a change.
	logic [BUSY_W-1:0]              key_busy_q;
	logic                           key_busy;

	// key_chain[r] is the 80-bit key register before round r; its top 64 bits
	// are round key r, and key_chain[ROUNDS] holds the whitening key.
	logic [prs_pkg::KEY_W-1:0]      key_chain [0:ROUNDS];

	// Links between round cells: link 0 feeds the first cell, link ROUNDS
	// leaves the last one.
	prs_pkg::ctl_t                  link_ctl   [0:ROUNDS];
	logic [prs_pkg::BLOCK_W-1:0]    link_data  [0:ROUNDS];
	logic                           link_ready [0:ROUNDS];

	logic [prs_pkg::RK_W-1:0]       white_rk;
	logic                           cfg_write;
	logic                           out_valid_q;
	logic [prs_pkg::BLOCK_W-1:0]    block_out_q;

	// ------------------------------------------------------------------
	// Configuration. Writes are always taken; an unknown index is ignored.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				prs_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				prs_pkg::REG_KEY_HIGH: key_high_q <= cfg_data[prs_pkg::KEY_HI_W-1:0];
				default: ;
			endcase
		end
	end

	// After reset or any key transfer the new key has to ripple through all
	// key cells, one per cycle, before a block may enter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_busy_q <= BUSY_W'(ROUNDS);
		end else if (cfg_write) begin
			key_busy_q <= BUSY_W'(ROUNDS);
		end else if (key_busy) begin
			key_busy_q <= key_busy_q - 1'b1;
		end
	end

	assign key_busy = (key_busy_q != '0);

	// ------------------------------------------------------------------
	// Key schedule chain. Cell r derives the key register for round r + 1
	// and folds in the round counter r + 1.
	// ------------------------------------------------------------------
	assign key_chain[0] = {key_high_q, key_low_q};

	for (genvar r = 0; r < ROUNDS; r++) begin : g_key
		prs_key_cell u_key_cell (
			.clk      (clk),
			.key_prev (key_chain[r]),
			.rnd_cnt  (prs_pkg::CNT_W'(r + 1)),
			.key_next (key_chain[r + 1])
		);
	end

	assign white_rk = key_chain[ROUNDS][prs_pkg::KEY_W-1 -: prs_pkg::RK_W];

	// ------------------------------------------------------------------
	// Input side. Decryption starts with the whitening key, so it is added
	// here before the first round cell.
	// ------------------------------------------------------------------
	assign in_stall = key_busy || !link_ready[0];

	assign link_ctl[0].valid   = in_valid && !key_busy;
	assign link_ctl[0].decrypt = opcode;
	assign link_data[0]        = opcode ? (block_in ^ white_rk) : block_in;

	// ------------------------------------------------------------------
	// Round cells. Cell j runs round j when encrypting and round
	// ROUNDS - 1 - j in reverse when decrypting.
	// ------------------------------------------------------------------
	for (genvar j = 0; j < ROUNDS; j++) begin : g_round
		prs_round_cell u_round_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_ctl   (link_ctl[j]),
			.up_data  (link_data[j]),
			.up_ready (link_ready[j]),
			.enc_rk   (key_chain[j][prs_pkg::KEY_W-1 -: prs_pkg::RK_W]),
			.dec_rk   (key_chain[ROUNDS - 1 - j][prs_pkg::KEY_W-1 -: prs_pkg::RK_W]),
			.dn_ctl   (link_ctl[j + 1]),
			.dn_data  (link_data[j + 1]),
			.dn_ready (link_ready[j + 1])
		);
	end

	// ------------------------------------------------------------------
	// Output register. Encryption ends with the whitening key. The register
	// frees the last cell whenever it is empty or its result is taken.
	// ------------------------------------------------------------------
	assign link_ready[ROUNDS] = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (link_ready[ROUNDS]) begin
			out_valid_q <= link_ctl[ROUNDS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (link_ready[ROUNDS] && link_ctl[ROUNDS].valid) begin
			block_out_q <= link_ctl[ROUNDS].decrypt ? link_data[ROUNDS]
			                                        : (link_data[ROUNDS] ^ white_rk);
		end
	end

	assign out_valid = out_valid_q;
	assign block_out = block_out_q;

endmodule

`default_nettype wire

[rtl/prs_checker.sv]
// ----------------------------------------------------------------------------
// PRESENT-80 port checker
// Watches the ports of the cipher over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_checker #(
	parameter int ROUNDS = 31
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic                              cfg_ready,
	input  wire logic [prs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [prs_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic                              opcode,
	input  wire logic [prs_pkg::BLOCK_W-1:0]       block_in,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic [prs_pkg::BLOCK_W-1:0]       block_out
);

	localparam int CNT_W = $clog2(ROUNDS + 3);

	logic             in_xfer;
	logic             out_xfer;
	logic [CNT_W-1:0] inflight_q;
	logic             unused_ok;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// The payload inputs are not checked here.
	assign unused_ok = ^{cfg_index, cfg_data, opcode, block_in};

	// Blocks taken in but not yet handed out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// A result is never offered without a block behind it.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inflight_q != '0) || (unused_ok && 1'b0) || (inflight_q != '0))
		else $error("result offered with no block in flight");

	// The pipeline never holds more blocks than its cells and output register.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(ROUNDS + 1))
		else $error("more blocks in flight than pipeline stages");

	// A key transfer holds off new blocks while the key chain refills.
	a_key_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("block taken right after a key transfer");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(block_out))
		else $error("stalled result changed");

endmodule

bind present80_block_cipher prs_checker #(.ROUNDS(ROUNDS)) u_prs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.opcode    (opcode),
	.block_in  (block_in),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.block_out (block_out)
);

`default_nettype wire

[tb/present80_block_cipher_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PRESENT-80 cipher checker
// Watches the register, block and result channels of the cipher, keeps its
// own copy of the key and round keys, and checks each result in order.
// ----------------------------------------------------------------------------

package present80_tb_pkg;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// Indexes with no register behind them; writes there must be dropped.
	localparam logic [prs_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [prs_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

endpackage

module present80_block_cipher_checker #(
	parameter int ROUNDS = 31
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [prs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prs_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              opcode,
	input  logic [prs_pkg::BLOCK_W-1:0]       block_in,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [prs_pkg::BLOCK_W-1:0]       block_out,
	output int                                errors,
	output int                                pending,
	output int                                checked,
	output int                                reg_writes
);

	import prs_pkg::*;
	import present80_tb_pkg::*;

	// S-box tables packed one nibble per input value, value 0 at the bottom.
	localparam logic [63:0] SBOX_FWD = 64'h2174_8FE3_DA09_B65C;
	localparam logic [63:0] SBOX_INV = 64'hA970_364B_D21C_8FE5;

	logic [KEY_W-1:0]   cipher_key = '0;
	logic [RK_W-1:0]    round_key [0:ROUNDS];
	logic [BLOCK_W-1:0] awaited_blocks [$];
	logic [BLOCK_W-1:0] want;

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
		reg_writes = 0;
	end

	function automatic logic [63:0] nibble_sub(input logic [63:0] s, input logic [63:0] box);
		logic [63:0] r;
		int idx;
		for (int n = 0; n < 16; n++) begin
			idx = s[4*n +: 4];
			r[4*n +: 4] = box[4*idx +: 4];
		end
		return r;
	endfunction

	// Bit i goes to 16*i mod 63; the top bit keeps its place.
	function automatic int scatter_pos(input int i);
		return (i == 63) ? 63 : (16 * i) % 63;
	endfunction

	function automatic logic [63:0] bit_scatter(input logic [63:0] s);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) begin
			r[scatter_pos(i)] = s[i];
		end
		return r;
	endfunction

	function automatic logic [63:0] bit_gather(input logic [63:0] s);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) begin
			r[i] = s[scatter_pos(i)];
		end
		return r;
	endfunction

	// Round key r is the top 64 bits of the key register before round r;
	// the last entry is the whitening key.
	function automatic void schedule_keys();
		logic [79:0] k;
		int idx;
		k = cipher_key;
		for (int r = 0; r <= ROUNDS; r++) begin
			round_key[r] = k[79:16];
			k = {k[18:0], k[79:19]};
			idx = k[79:76];
			k[79:76] = SBOX_FWD[4*idx +: 4];
			k[19:15] = k[19:15] ^ 5'(r + 1);
		end
	endfunction

	function automatic logic [63:0] present_crypt(input logic op, input logic [63:0] blk);
		logic [63:0] s;
		s = blk;
		if (op == OP_DECRYPT) begin
			s = s ^ round_key[ROUNDS];
			for (int r = ROUNDS - 1; r >= 0; r--) begin
				s = nibble_sub(bit_gather(s), SBOX_INV) ^ round_key[r];
			end
		end else begin
			for (int r = 0; r < ROUNDS; r++) begin
				s = bit_scatter(nibble_sub(s ^ round_key[r], SBOX_FWD));
			end
			s = s ^ round_key[ROUNDS];
		end
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key = '0;
			schedule_keys();
			awaited_blocks.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY_LOW: cipher_key[63:0] = cfg_data;
					REG_KEY_HIGH: cipher_key[79:64] = cfg_data[KEY_HI_W-1:0];
					default: ;
				endcase
				schedule_keys();
				reg_writes++;
			end
			if (out_valid && !out_stall) begin
				if (awaited_blocks.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %h",
						$time, block_out);
				end else begin
					want = awaited_blocks.pop_front();
					checked++;
					if (block_out !== want) begin
						errors++;
						$display("%0t: block_out mismatch, expected %h, actual %h",
							$time, want, block_out);
					end
				end
			end
			if (in_valid && !in_stall) begin
				awaited_blocks.push_back(present_crypt(opcode, block_in));
			end
			pending = awaited_blocks.size();
		end
	end

endmodule

[tb/tb_present80_block_cipher.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PRESENT-80 cipher testbench
// Drives encrypt and decrypt blocks under a series of keys, with random
// idling on both channels and one long output hold; a checker alongside
// the cipher predicts every result and counts the mismatches.
// ----------------------------------------------------------------------------

module tb_present80_block_cipher;

	import prs_pkg::*;
	import present80_tb_pkg::*;

	localparam int ROUNDS     = 31;
	// Pipeline depth plus a margin, waited out once the last result is in.
	localparam int SETTLE     = ROUNDS + 8;
	// Length of the deliberate output hold that backs the pipeline up.
	localparam int LONG_HOLD  = 150;
	localparam int PHASES     = 8;
	localparam int PHASE_ITEMS = 80;
	// Longest legal quiet stretch is the long hold plus a drain, a key
	// schedule refill and an idle burst.
	localparam int LIMIT      = 2000;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DAT_W-1:0]   cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   opcode;
	logic [BLOCK_W-1:0]     block_in;
	logic                   out_valid;
	logic                   out_stall;
	logic [BLOCK_W-1:0]     block_out;

	int errors;
	int pending;
	int checked;
	int reg_writes;

	// Idling controls, set per phase by the stimulus process.
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	bit long_hold_req = 1'b0;
	int n_decrypt     = 0;

	present80_block_cipher #(
		.ROUNDS(ROUNDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.block_in(block_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.block_out(block_out)
	);

	present80_block_cipher_checker #(
		.ROUNDS(ROUNDS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.block_in(block_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.block_out(block_out),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.reg_writes(reg_writes)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Presents one register write and holds it until the transfer happens.
	// Valid is left high so that back-to-back writes need no lowering in
	// between; the caller drops it once the batch is done.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Loads a full key. The high word carries junk above bit 15, which the
	// block must discard, and a write to an unused index may be slipped in.
	task automatic program_key(input logic [63:0] lo, input logic [63:0] hi, input bit junk);
		write_reg(REG_KEY_HIGH, hi);
		if (junk) begin
			write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
		end
		write_reg(REG_KEY_LOW, lo);
		cfg_valid <= 1'b0;
	endtask

	// Offers one block, optionally after an idle burst, and returns on the
	// edge at which the transfer takes place with valid still high.
	task automatic send_block(input logic op, input logic [63:0] blk);
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(17, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		block_in <= blk;
		if (op == OP_DECRYPT) n_decrypt++;
		do @(posedge clk); while (in_stall);
	endtask

	// Waits until every block sent so far has come back. The first edge is
	// always waited for so that the checker has seen the latest transfer.
	task automatic drain;
		do @(posedge clk); while (pending != 0);
	endtask

	// Extremes and a few fixed patterns in both directions under one key.
	task automatic directed_blocks;
		send_block(OP_ENCRYPT, 64'h0000_0000_0000_0000);
		send_block(OP_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
		send_block(OP_DECRYPT, 64'h0000_0000_0000_0000);
		send_block(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
		send_block(OP_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
		send_block(OP_DECRYPT, 64'h5555_5555_5555_5555);
		send_block(OP_ENCRYPT, 64'h8000_0000_0000_0001);
		in_valid <= 1'b0;
		drain();
	endtask

	// The receiving side: random stall bursts, plus the long hold on request.
	// Stall always drops between bursts.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(17, 1)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Ends the run if no transfer of any kind happens for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_present80_block_cipher: done, errors");
		$finish;
	end

	initial begin : stimulus
		logic [63:0] blk;
		logic [63:0] key_lo;
		logic [63:0] key_hi;
		int pick;

		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		opcode    <= OP_ENCRYPT;
		block_in  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// The all-zero key straight out of reset. The block stalls its input
		// while the key schedule refills, which the handshake absorbs.
		directed_blocks();

		// All-ones key, with both unused indexes written beforehand; their
		// data must not leak into the key.
		write_reg(REG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF);
		program_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		directed_blocks();

		// Random phases, each under a fresh key. The first uses a mixed
		// extreme key; the last runs with no idling at all.
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				key_lo = 64'hFFFF_FFFF_FFFF_FFFF;
				key_hi = 64'hFFFF_FFFF_FFFF_0000;
			end else begin
				key_lo = {$urandom, $urandom};
				key_hi = {$urandom, $urandom};
			end
			program_key(key_lo, key_hi, $urandom_range(1));

			if (p == PHASES - 1) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end else begin
				pick = $urandom_range(2);
				src_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 25;
				pick = $urandom_range(2);
				sink_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 4 : 15;
			end
			// One phase opens with the long output hold while blocks keep
			// coming, so the pipeline fills and pushes back on the input.
			if (p == 1) long_hold_req = 1'b1;

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(9))
					0: blk = '0;
					1: blk = '1;
					2: blk = 64'd1 << $urandom_range(63);
					default: blk = {$urandom, $urandom};
				endcase
				send_block($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT, blk);
			end
			in_valid <= 1'b0;
			drain();
		end

		repeat (SETTLE) @(posedge clk);

		$display("Checked %0d blocks (%0d decryptions) over %0d register transfers,",
			checked, n_decrypt, reg_writes);
		$display("including zero and all-ones keys and a %0d-cycle output hold.", LONG_HOLD);
		if (errors == 0 && pending == 0)
			$display("tb_present80_block_cipher: done, clean");
		else
			$display("tb_present80_block_cipher: done, errors");
		$finish;
	end

endmodule
